/* sv/epdu_pkg.sv */
// ----------------------------------------------------------------------------
// Exception priority delivery package
// Request codes, masks, vector table and payload types of the exception unit.
// ----------------------------------------------------------------------------
package epdu_pkg;

    localparam int unsigned NUM_EXC = 11;
    localparam int unsigned NUM_SYNC = 7;

    localparam logic [31:0] EE_BIT     = 32'h0000_8000;
    localparam logic [31:0] IP_BIT     = 32'h0000_0040;
    localparam logic [31:0] POW_BIT    = 32'h0004_0000;
    localparam logic [31:0] SAVE_MASK  = 32'h87C0_FFFF;
    localparam logic [31:0] ENTRY_CLR  = 32'h0004_EF36;
    localparam logic [31:0] HIGH_PAGE  = 32'hFFF0_0000;
    localparam logic [31:0] RET_MASK   = 32'h87C0_FF73;
    localparam logic [31:0] PROG_EXTRA = 32'h0008_0000;
    localparam logic [31:0] ALIGN_MASK = ~32'd3;
    localparam logic [31:0] PC_STEP    = 32'd4;

    localparam int unsigned PROG_IDX    = 1;
    localparam int unsigned SYSCALL_IDX = 5;
    localparam int unsigned TRACE_IDX   = 6;

    typedef enum logic [2:0] {
        REQ_RAISE      = 3'd0,
        REQ_DELIVER    = 3'd1,
        REQ_RFI        = 3'd2,
        REQ_WRITE_MSR  = 3'd3,
        REQ_WRITE_SRR0 = 3'd4,
        REQ_WRITE_SRR1 = 3'd5
    } req_e;

    typedef logic [12:0] vec_t;

    function automatic vec_t exc_vector(input int unsigned idx);
        vec_t v;
        v = '0;
        unique case (idx)
            0:       v = 13'h0400;
            1:       v = 13'h0700;
            2:       v = 13'h0800;
            3:       v = 13'h0300;
            4:       v = 13'h0600;
            5:       v = 13'h0C00;
            6:       v = 13'h0D00;
            7:       v = 13'h0500;
            8:       v = 13'h0900;
            9:       v = 13'h0F00;
            10:      v = 13'h1700;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic [2:0]  req_type;
        logic [10:0] raise_bits;
        logic [31:0] current_pc;
        logic [31:0] data_value;
    } epdu_in_t;

    typedef struct packed {
        logic        taken;
        logic [12:0] vector_offset;
        logic        redirect;
        logic [31:0] new_pc;
        logic        exit_request;
        logic [31:0] msr_now;
        logic [31:0] srr0_now;
        logic [31:0] srr1_now;
        logic [10:0] pending_now;
        logic        attention;
    } epdu_out_t;

endpackage

/* sv/exception_priority_delivery_unit.sv */
// ----------------------------------------------------------------------------
// Exception priority delivery unit
// Pending exceptions, fixed-priority delivery, return from interrupt and
// MSR/SRR0/SRR1 writes, one request per cycle while s_ready is high.
// ----------------------------------------------------------------------------
//  channel   ports                      payload      role
//  s_        s_valid s_ready s_data     epdu_in_t    request in
//  m_        m_valid m_ready m_data     epdu_out_t   one result per request
//
//  One request per cycle while s_ready is high; each result is registered.
//  State (pending, MSR, SRR0, SRR1) updates at the accepting edge, so the
//  next request sees it at once. A two-entry output (register plus skid)
//  lets s_ready hold while one result waits; s_ready drops only when both
//  are full. Synchronous reset clears state and both output entries.
module exception_priority_delivery_unit
    import epdu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  epdu_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output epdu_out_t m_data
);

    logic [10:0] pending_reg, pending_next;
    logic [31:0] msr_reg, msr_next;
    logic [31:0] srr0_reg, srr0_next;
    logic [31:0] srr1_reg, srr1_next;

    epdu_out_t out_reg, out_next;
    epdu_out_t skid_reg, skid_next;
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;

    epdu_out_t res;
    logic      s_fire, m_fire;

    logic [10:0] eligible, sel_oh;
    logic        sel_any;
    vec_t        sel_vec;
    logic [31:0] msr_entry;

    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = out_valid_reg && m_ready;

    always_comb begin
        if (pending_reg[NUM_SYNC-1:0] != '0) begin
            eligible = {{(NUM_EXC-NUM_SYNC){1'b0}}, pending_reg[NUM_SYNC-1:0]};
        end else if ((msr_reg & EE_BIT) != '0) begin
            eligible = pending_reg;
        end else begin
            eligible = '0;
        end
        sel_oh  = eligible & (~eligible + 11'd1);
        sel_any = eligible != '0;
        sel_vec = '0;
        for (int i = 0; i < NUM_EXC; i++) begin
            sel_vec = sel_vec | (sel_oh[i] ? exc_vector(i) : '0);
        end
        msr_entry = msr_reg & ~ENTRY_CLR;
    end

    always_comb begin
        pending_next = pending_reg;
        msr_next     = msr_reg;
        srr0_next    = srr0_reg;
        srr1_next    = srr1_reg;
        res          = '0;
        unique case (s_data.req_type)
            REQ_RAISE: begin
                pending_next = pending_reg | s_data.raise_bits;
            end
            REQ_DELIVER: begin
                if (sel_any) begin
                    srr0_next = (sel_oh[SYSCALL_IDX] || sel_oh[TRACE_IDX])
                              ? s_data.current_pc + PC_STEP : s_data.current_pc;
                    srr1_next = (msr_reg & SAVE_MASK)
                              | (sel_oh[PROG_IDX] ? PROG_EXTRA : '0);
                    msr_next  = msr_entry;
                    pending_next     = pending_reg & ~sel_oh;
                    res.taken        = 1'b1;
                    res.vector_offset = sel_vec;
                    res.redirect     = 1'b1;
                    res.new_pc       = (((msr_entry & IP_BIT) != '0) ? HIGH_PAGE : '0)
                                     + {19'd0, sel_vec};
                    res.exit_request = 1'b1;
                end
            end
            REQ_RFI: begin
                msr_next = ((msr_reg & ~RET_MASK) | (srr1_reg & RET_MASK)) & ~POW_BIT;
                res.redirect     = 1'b1;
                res.new_pc       = srr0_reg & ALIGN_MASK;
                res.exit_request = 1'b1;
            end
            REQ_WRITE_MSR: begin
                msr_next = s_data.data_value;
                res.exit_request = ((s_data.data_value & EE_BIT) != '0)
                                 && (pending_reg != '0);
            end
            REQ_WRITE_SRR0: begin
                srr0_next = s_data.data_value;
            end
            REQ_WRITE_SRR1: begin
                srr1_next = s_data.data_value;
            end
            default: begin
            end
        endcase
        res.msr_now     = msr_next;
        res.srr0_now    = srr0_next;
        res.srr1_now    = srr1_next;
        res.pending_now = pending_next;
        res.attention   = (pending_next[NUM_SYNC-1:0] != '0)
                        || (((msr_next & EE_BIT) != '0) && (pending_next != '0));
    end

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (m_fire) begin
            out_valid_next = 1'b0;
        end
        if (skid_valid_reg && m_fire) begin
            out_next        = skid_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        if (s_fire) begin
            if (!out_valid_reg || m_fire) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg    <= '0;
            msr_reg        <= '0;
            srr0_reg       <= '0;
            srr1_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                pending_reg <= pending_next;
                msr_reg     <= msr_next;
                srr0_reg    <= srr0_next;
                srr1_reg    <= srr1_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

/* sv/epdu_checker.sv */
// ----------------------------------------------------------------------------
// Exception priority delivery checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module epdu_checker
    import epdu_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input epdu_out_t m_data
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result valid or input blocked after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_taken_redirect: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.taken |-> m_data.redirect && m_data.exit_request
                                    && (m_data.vector_offset != '0))
        else $error("delivery without redirect or vector");

    a_no_redirect: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.redirect |-> !m_data.taken && (m_data.new_pc == '0)
                                        && (m_data.vector_offset == '0))
        else $error("target without redirect");

    a_attention: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.pending_now[NUM_SYNC-1:0] != '0) |-> m_data.attention)
        else $error("synchronous pending without attention");

endmodule

bind exception_priority_delivery_unit epdu_checker u_epdu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
